[design/uart_baud_divisor_and_line_control_defines.svh]
// ----------------------------------------------------------------------------
// uart baud divisor assertion macros
// shared concurrent assertion forms, clocked and reset-gated
// ----------------------------------------------------------------------------
`ifndef UART_BAUD_DIVISOR_AND_LINE_CONTROL_DEFINES_SVH
`define UART_BAUD_DIVISOR_AND_LINE_CONTROL_DEFINES_SVH

// same-cycle implication
`define UBDLC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define UBDLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/ubdlc_pkg.sv]
// ----------------------------------------------------------------------------
// ubdlc_pkg
// types, codes and the slot pattern table for the baud divisor block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ubdlc_pkg;

    localparam int RATE_W  = 32;
    localparam int BAUD_W  = 24;
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO_BAUD = 3'd1,
        ST_BAD_DATA  = 3'd2,
        ST_BAD_PAR   = 3'd3,
        ST_BAD_STOP  = 3'd4
    } t_status;

    localparam logic [3:0] DATA_BITS_MIN = 4'd5;
    localparam logic [3:0] DATA_BITS_MAX = 4'd8;

    localparam logic [1:0] PAR_NONE = 2'd0;
    localparam logic [1:0] PAR_ODD  = 2'd1;
    localparam logic [1:0] PAR_EVEN = 2'd2;

    localparam logic [2:0] PCODE_NONE = 3'd0;
    localparam logic [2:0] PCODE_ODD  = 3'd4;
    localparam logic [2:0] PCODE_EVEN = 3'd5;

    localparam logic [1:0] STOP_ONE = 2'd1;
    localparam logic [1:0] STOP_TWO = 2'd2;

    localparam logic [15:0] SLOT_TABLE [16] = '{
        16'h0000, 16'h0080, 16'h0808, 16'h0888,
        16'h2222, 16'h4924, 16'h4a52, 16'h54aa,
        16'h5555, 16'hd555, 16'hd5d5, 16'hddd5,
        16'hdddd, 16'hdfdd, 16'hdfdf, 16'hffdf
    };

    typedef struct packed {
        logic [BAUD_W-1:0] baud_rate;
        logic [3:0]        data_bits;
        logic [1:0]        parity_mode;
        logic [1:0]        stop_bits;
    } t_uart_in;

    typedef struct packed {
        logic [2:0]        status;
        logic [RATE_W-1:0] divisor;
        logic [15:0]       frac_slot;
        logic [5:0]        line_control;
    } t_uart_out;

    // classified request handed from front to back
    typedef struct packed {
        t_status           status;
        logic [5:0]        line_control;
        logic [BAUD_W-1:0] baud_rate;
    } t_job;

endpackage

[design/ubdlc_front.sv]
// ----------------------------------------------------------------------------
// ubdlc_front
// accepts requests, checks the format and builds the line-control code
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ubdlc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ubdlc_pkg::t_uart_in  i_in_data,
    output logic                 o_push_valid,
    input  logic                 i_push_ready,
    output ubdlc_pkg::t_job      o_push_job
);
    import ubdlc_pkg::*;

    logic    r_valid;
    t_job    r_job;
    t_job    n_job;
    t_status st;
    logic [2:0] pcode;
    logic [1:0] dcode;
    logic       scode;
    logic       accept;

    always_comb begin
        if (i_in_data.data_bits < DATA_BITS_MIN || i_in_data.data_bits > DATA_BITS_MAX) begin
            st = ST_BAD_DATA;
        end else if (i_in_data.parity_mode != PAR_NONE && i_in_data.parity_mode != PAR_ODD
                     && i_in_data.parity_mode != PAR_EVEN) begin
            st = ST_BAD_PAR;
        end else if (i_in_data.stop_bits != STOP_ONE && i_in_data.stop_bits != STOP_TWO) begin
            st = ST_BAD_STOP;
        end else if (i_in_data.baud_rate == '0) begin
            st = ST_ZERO_BAUD;
        end else begin
            st = ST_OK;
        end

        case (i_in_data.parity_mode)
            PAR_ODD:  pcode = PCODE_ODD;
            PAR_EVEN: pcode = PCODE_EVEN;
            default:  pcode = PCODE_NONE;
        endcase

        dcode = 2'(i_in_data.data_bits - DATA_BITS_MIN);
        scode = (i_in_data.stop_bits == STOP_TWO);

        n_job.status       = st;
        n_job.line_control = (st == ST_OK) ? {pcode, scode, dcode} : 6'd0;
        n_job.baud_rate    = i_in_data.baud_rate;
    end

    assign o_in_ready   = !r_valid || i_push_ready;
    assign accept       = i_in_valid && o_in_ready;
    assign o_push_valid = r_valid;
    assign o_push_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

[design/ubdlc_queue.sv]
// ----------------------------------------------------------------------------
// ubdlc_queue
// short first-in first-out queue of classified requests
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "uart_baud_divisor_and_line_control_defines.svh"

module ubdlc_queue #(
    parameter int QueueDepth = ubdlc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  ubdlc_pkg::t_job i_push_job,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output ubdlc_pkg::t_job o_pop_job
);
    import ubdlc_pkg::*;

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    t_job            r_mem [QueueDepth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic [PtrW-1:0] n_wr_ptr;
    logic [PtrW-1:0] n_rd_ptr;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != CntW'(QueueDepth));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = (r_wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    `UBDLC_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CntW'(QueueDepth), "queue count over depth")
    `UBDLC_ASSERT_NEXT(a_push_only_grows, i_clk, i_rst_n, push && !pop, r_count == $past(r_count) + 1'b1, "push lost")
    `UBDLC_ASSERT_NOW(a_ptrs_match_empty, i_clk, i_rst_n, r_count == '0, r_wr_ptr == r_rd_ptr, "pointers differ while empty")

endmodule

[design/ubdlc_back.sv]
// ----------------------------------------------------------------------------
// ubdlc_back
// pipelined restoring divider, slot table lookup and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "uart_baud_divisor_and_line_control_defines.svh"

module ubdlc_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [ubdlc_pkg::RATE_W-1:0]   i_clock_rate,
    input  logic                           i_job_valid,
    output logic                           o_job_ready,
    input  ubdlc_pkg::t_job                i_job,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output ubdlc_pkg::t_uart_out           o_out_data
);
    import ubdlc_pkg::*;

    // one quotient bit per stage, dividend taken msb first
    localparam int Stages = RATE_W;

    logic              r_stg_v   [Stages+1];
    logic [BAUD_W-1:0] r_stg_rem [Stages+1];
    logic [RATE_W-1:0] r_stg_quo [Stages+1];
    t_job              r_stg_job [Stages+1];

    logic              r_out_valid;
    t_uart_out         r_out;
    t_uart_out         n_out;
    logic              advance;
    logic [RATE_W-1:0] quo;
    logic [RATE_W-1:0] quo_hi;
    t_job              last_job;

    // whole pipeline moves unless a finished result is held
    assign advance     = !r_out_valid || i_out_ready;
    assign o_job_ready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_v[0] <= 1'b0;
        end else if (advance) begin
            r_stg_v[0] <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_stg_rem[0] <= '0;
            r_stg_quo[0] <= '0;
            r_stg_job[0] <= i_job;
        end
    end

    for (genvar k = 0; k < Stages; k++) begin : g_div
        logic [BAUD_W:0]   shifted;
        logic              ge;
        logic [BAUD_W:0]   diff;
        logic [BAUD_W-1:0] rem_nxt;

        always_comb begin
            shifted = {r_stg_rem[k], i_clock_rate[Stages-1-k]};
            ge      = (shifted >= {1'b0, r_stg_job[k].baud_rate});
            diff    = shifted - {1'b0, r_stg_job[k].baud_rate};
            rem_nxt = ge ? diff[BAUD_W-1:0] : shifted[BAUD_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg_v[k+1] <= 1'b0;
            end else if (advance) begin
                r_stg_v[k+1] <= r_stg_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_stg_rem[k+1] <= rem_nxt;
                r_stg_quo[k+1] <= {r_stg_quo[k][RATE_W-2:0], ge};
                r_stg_job[k+1] <= r_stg_job[k];
            end
        end
    end

    // quotient of rate/baud: upper bits less one give the divisor, low nibble the slot
    always_comb begin
        quo      = r_stg_quo[Stages];
        last_job = r_stg_job[Stages];
        quo_hi   = {4'd0, quo[RATE_W-1:4]};
        if (last_job.status == ST_OK) begin
            n_out.status       = last_job.status;
            n_out.divisor      = quo_hi - 1'b1;
            n_out.frac_slot    = SLOT_TABLE[quo[3:0]];
            n_out.line_control = last_job.line_control;
        end else begin
            n_out.status       = last_job.status;
            n_out.divisor      = '0;
            n_out.frac_slot    = '0;
            n_out.line_control = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_stg_v[Stages];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `UBDLC_ASSERT_NOW(a_err_zero_payload, i_clk, i_rst_n, r_out_valid && r_out.status != ST_OK, r_out.divisor == '0 && r_out.frac_slot == '0 && r_out.line_control == '0, "error beat with payload")
    `UBDLC_ASSERT_NEXT(a_stall_freezes_pipe, i_clk, i_rst_n, !advance, r_stg_v[Stages] == $past(r_stg_v[Stages]) && r_stg_v[0] == $past(r_stg_v[0]), "pipeline moved while stalled")
    `UBDLC_ASSERT_NEXT(a_last_to_out, i_clk, i_rst_n, advance && r_stg_v[Stages], r_out_valid, "finished beat dropped")

endmodule

[design/uart_baud_divisor_and_line_control.sv]
// ----------------------------------------------------------------------------
// uart_baud_divisor_and_line_control
// baud divisor, fractional slot word and line-control code from a request
// ----------------------------------------------------------------------------
// One request beat in, one result beat out, in order. A new beat is taken every
// cycle while the result side does not stall. The divider resolves one quotient
// bit of clock_rate / baud_rate per pipeline stage over 32 stages. The quotient
// gives both answers: its upper 28 bits are clock_rate / (16 * baud_rate), so
// the divisor is that minus one (wrapping to all ones below 16 * baud_rate), and
// its low four bits select the fractional slot pattern. Format checks run in the
// front stage in the order data bits, parity, stop bits, then baud; the first
// failure sets status and zeroes divisor, slot word and line control. A zero
// baud is flagged and its divider result is discarded. The user must write
// clock_rate through the configuration port only while the block holds no
// request; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_baud_divisor_and_line_control #(
    parameter int QueueDepth = ubdlc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ubdlc_pkg::t_uart_in           i_in_data,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ubdlc_pkg::t_uart_out          o_out_data,
    // clock rate register write
    input  logic                          i_cfg_wr_en,
    input  logic [ubdlc_pkg::RATE_W-1:0]  i_cfg_wr_data
);
    import ubdlc_pkg::*;

    logic [RATE_W-1:0] r_clock_rate;

    // front to queue
    logic fq_valid;
    logic fq_ready;
    t_job fq_job;

    // queue to back
    logic qb_valid;
    logic qb_ready;
    t_job qb_job;

    // clock Hz, held steady by user while requests are in flight, unenforced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_rate <= '0;
        end else if (i_cfg_wr_en) begin
            r_clock_rate <= i_cfg_wr_data;
        end
    end

    // classify and encode line control
    ubdlc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_push_valid (fq_valid),
        .i_push_ready (fq_ready),
        .o_push_job   (fq_job)
    );

    // decouples the front from divider stalls
    ubdlc_queue #(
        .QueueDepth (QueueDepth)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_job   (fq_job),
        .o_pop_valid  (qb_valid),
        .i_pop_ready  (qb_ready),
        .o_pop_job    (qb_job)
    );

    // divide, look up the slot word, register the result beat
    ubdlc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clock_rate (r_clock_rate),
        .i_job_valid  (qb_valid),
        .o_job_ready  (qb_ready),
        .i_job        (qb_job),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

[bench/uart_baud_divisor_and_line_control_tb.sv]
// ----------------------------------------------------------------------------
// uart_baud_divisor_and_line_control_tb
// self-checking bench: directed table, then random requests per clock setting
// ----------------------------------------------------------------------------
// Requests go in through the valid/ready request channel. Each beat's expected
// result comes from its typed directed table row or from a local model of the
// divisor, slot pattern and line-control encoding, and is queued at acceptance.
// Result beats are checked field by field, in order, against that queue. The
// clock rate register is rewritten between phases once the pipeline has drained.
// Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_baud_divisor_and_line_control_tb;
    import ubdlc_pkg::*;

    localparam int ITEMS_PER_GROUP = 219;    // eight groups, about 1750 beats
    localparam int RATE_GROUPS     = 8;
    localparam int DRAIN_CYCLES    = 48;     // extra idle wait after draining, before a clock rate write
    localparam int TAIL_CYCLES     = 60;
    localparam int CYCLE_LIMIT     = 400000;

    // one row of the directed table; typed rows carry their own result
    typedef struct packed {
        logic [RATE_W-1:0] rate;
        t_uart_in          req;
        logic              typed;
        t_uart_out         result;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_uart_in    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_uart_out   out_data;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    t_uart_out   pending_results[$];
    t_stim_row   stim_rows[$];
    logic [31:0] clock_hz = '0;     // mirror of the block's clock rate register
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          errors = 0;
    int          cycles = 0;

    uart_baud_divisor_and_line_control dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in_data     (in_data),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_data    (out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // run guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("uart_baud_divisor_and_line_control_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // local model
    // ------------------------------------------------------------------------

    // slot pattern words, indexed by the fractional sixteenth
    function automatic logic [15:0] slot_pattern(input logic [3:0] sixteenth);
        case (sixteenth)
            4'd0:    return 16'h0000;
            4'd1:    return 16'h0080;
            4'd2:    return 16'h0808;
            4'd3:    return 16'h0888;
            4'd4:    return 16'h2222;
            4'd5:    return 16'h4924;
            4'd6:    return 16'h4a52;
            4'd7:    return 16'h54aa;
            4'd8:    return 16'h5555;
            4'd9:    return 16'hd555;
            4'd10:   return 16'hd5d5;
            4'd11:   return 16'hddd5;
            4'd12:   return 16'hdddd;
            4'd13:   return 16'hdfdd;
            4'd14:   return 16'hdfdf;
            default: return 16'hffdf;
        endcase
    endfunction

    function automatic t_uart_out line_setup(input t_uart_in req, input logic [31:0] rate);
        t_uart_out   r;
        logic [63:0] span;
        logic [63:0] quot;
        logic [63:0] rem;
        logic [63:0] sixteenth;
        logic [2:0]  pcode;
        logic [3:0]  dcode;
        r = '0;
        // format checks, first failure wins
        if (req.data_bits < DATA_BITS_MIN || req.data_bits > DATA_BITS_MAX) begin
            r.status = ST_BAD_DATA;
        end else if (req.parity_mode != PAR_NONE && req.parity_mode != PAR_ODD &&
                     req.parity_mode != PAR_EVEN) begin
            r.status = ST_BAD_PAR;
        end else if (req.stop_bits != STOP_ONE && req.stop_bits != STOP_TWO) begin
            r.status = ST_BAD_STOP;
        end else if (req.baud_rate == '0) begin
            r.status = ST_ZERO_BAUD;
        end else begin
            span      = {36'd0, req.baud_rate, 4'd0};
            quot      = {32'd0, rate} / span;
            rem       = {32'd0, rate} % span;
            sixteenth = rem / {40'd0, req.baud_rate};
            case (req.parity_mode)
                PAR_ODD:  pcode = PCODE_ODD;
                PAR_EVEN: pcode = PCODE_EVEN;
                default:  pcode = PCODE_NONE;
            endcase
            dcode          = req.data_bits - DATA_BITS_MIN;
            r.status       = ST_OK;
            r.divisor      = quot[31:0] - 32'd1;    // wraps below one span
            r.frac_slot    = slot_pattern(sixteenth[3:0]);
            r.line_control = {pcode, req.stop_bits == STOP_TWO, dcode[1:0]};
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic bit roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic t_uart_in make_req(input logic [23:0] baud, input logic [3:0] dbits,
                                          input logic [1:0] par, input logic [1:0] stop);
        t_uart_in r;
        r.baud_rate   = baud;
        r.data_bits   = dbits;
        r.parity_mode = par;
        r.stop_bits   = stop;
        return r;
    endfunction

    task automatic add_row(input logic [31:0] rate, input t_uart_in req, input logic typed,
                           input t_status st, input logic [31:0] div,
                           input logic [15:0] slot, input logic [5:0] lcr);
        t_stim_row row;
        row.rate                = rate;
        row.req                 = req;
        row.typed               = typed;
        row.result.status       = st;
        row.result.divisor      = div;
        row.result.frac_slot    = slot;
        row.result.line_control = lcr;
        stim_rows.push_back(row);
    endtask

    // mostly well-formed requests with bauds that land in useful divisor ranges,
    // the rest zero baud or raw noise on every field
    function automatic t_uart_in random_req(input logic [31:0] rate);
        t_uart_in    r;
        logic [31:0] k;
        logic [31:0] b;
        r = t_uart_in'($urandom);
        if ($urandom_range(99) < 80) begin
            r.data_bits   = 4'($urandom_range(8, 5));
            r.parity_mode = 2'($urandom_range(2, 0));
            r.stop_bits   = 2'($urandom_range(2, 1));
            case ($urandom_range(9))
                0, 1, 2: r.baud_rate = 24'($urandom);
                3, 4:    r.baud_rate = 24'($urandom_range(1000, 1));
                5, 6: begin
                    case ($urandom_range(7))
                        0:       r.baud_rate = 300;
                        1:       r.baud_rate = 1200;
                        2:       r.baud_rate = 9600;
                        3:       r.baud_rate = 19200;
                        4:       r.baud_rate = 38400;
                        5:       r.baud_rate = 57600;
                        6:       r.baud_rate = 115200;
                        default: r.baud_rate = 921600;
                    endcase
                end
                7, 8: begin
                    // near an exact multiple of the clock, any fraction
                    k = $urandom_range(4096, 1);
                    b = rate / (k * 32'd16) + $urandom_range(1);
                    r.baud_rate = (b[23:0] == '0) ? 24'd1 : b[23:0];
                end
                default: r.baud_rate = '0;
            endcase
        end
        return r;
    endfunction

    // one request beat; entered and left just after a falling edge
    task automatic send_beat(input t_uart_in req, input t_uart_out want);
        while (roll(src_idle_pct)) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        pending_results.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained;
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // register writes only with nothing in flight
    task automatic set_clock_rate(input logic [31:0] rate);
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= rate;
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
        clock_hz     = rate;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    always @(negedge i_clk) begin
        out_ready <= !roll(sink_stall_pct);
    end

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        errors++;
    endtask

    always @(posedge i_clk) begin : check_beat
        t_uart_out want;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing pending, expected none, got %0h",
                         $time, out_data);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (out_data.status !== want.status)
                    report_field("status", 32'(want.status), 32'(out_data.status));
                if (out_data.divisor !== want.divisor)
                    report_field("divisor", want.divisor, out_data.divisor);
                if (out_data.frac_slot !== want.frac_slot)
                    report_field("frac_slot", 32'(want.frac_slot), 32'(out_data.frac_slot));
                if (out_data.line_control !== want.line_control)
                    report_field("line_control", 32'(want.line_control),
                                 32'(out_data.line_control));
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial begin
        t_uart_in  req;
        t_stim_row row;
        logic [31:0] rate;

        // clock rate still at its reset value of zero: every good request
        // underflows to an all-ones divisor with the zero slot word
        add_row(0, make_req(9600, 8, PAR_NONE, STOP_ONE), 1, ST_OK, 32'hffff_ffff, 0, 6'h03);
        add_row(0, make_req(0, 8, PAR_NONE, STOP_ONE), 1, ST_ZERO_BAUD, 0, 0, 0);
        add_row(0, make_req(9600, 4, PAR_NONE, STOP_ONE), 1, ST_BAD_DATA, 0, 0, 0);
        add_row(0, make_req(9600, 9, PAR_NONE, STOP_ONE), 1, ST_BAD_DATA, 0, 0, 0);
        // data bits checked ahead of everything else
        add_row(0, make_req(0, 0, 2'd3, 2'd0), 1, ST_BAD_DATA, 0, 0, 0);
        add_row(0, make_req(0, 15, 2'd3, 2'd3), 1, ST_BAD_DATA, 0, 0, 0);
        add_row(0, make_req(9600, 8, 2'd3, STOP_ONE), 1, ST_BAD_PAR, 0, 0, 0);
        add_row(0, make_req(0, 5, 2'd3, 2'd0), 1, ST_BAD_PAR, 0, 0, 0);
        // stop bit codes other than one and two are rejected
        add_row(0, make_req(9600, 8, PAR_NONE, 2'd0), 1, ST_BAD_STOP, 0, 0, 0);
        add_row(0, make_req(0, 7, PAR_EVEN, 2'd3), 1, ST_BAD_STOP, 0, 0, 0);
        add_row(0, make_req(24'hff_ffff, 5, PAR_EVEN, STOP_TWO), 1, ST_OK,
                32'hffff_ffff, 0, 6'h2c);
        // common clock, data lengths of six to eight bits, every parity and stop setting
        add_row(50_000_000, make_req(115200, 8, PAR_NONE, STOP_ONE), 0, ST_OK, 0, 0, 0);
        add_row(50_000_000, make_req(9600, 7, PAR_EVEN, STOP_ONE), 0, ST_OK, 0, 0, 0);
        add_row(50_000_000, make_req(19200, 6, PAR_ODD, STOP_TWO), 0, ST_OK, 0, 0, 0);
        // span equal to the clock, then just past it (divisor wraps)
        add_row(50_000_000, make_req(3_125_000, 5, PAR_NONE, STOP_TWO), 0, ST_OK, 0, 0, 0);
        add_row(50_000_000, make_req(3_125_001, 5, PAR_NONE, STOP_TWO), 0, ST_OK, 0, 0, 0);
        add_row(50_000_000, make_req(1, 8, PAR_ODD, STOP_TWO), 0, ST_OK, 0, 0, 0);
        // full-scale clock against the smallest and largest baud
        add_row(32'hffff_ffff, make_req(1, 8, PAR_NONE, STOP_ONE), 1, ST_OK,
                32'h0fff_fffe, 16'hffdf, 6'h03);
        add_row(32'hffff_ffff, make_req(24'hff_ffff, 8, PAR_NONE, STOP_ONE), 1, ST_OK,
                32'h0000_000f, 16'h0000, 6'h03);
        add_row(32'hffff_ffff, make_req(24'hff_ffff, 5, PAR_EVEN, STOP_TWO), 0, ST_OK, 0, 0, 0);
        add_row(32'hffff_ffff, make_req(300, 8, PAR_ODD, STOP_ONE), 0, ST_OK, 0, 0, 0);
        add_row(32'hffff_ffff, make_req(24'h80_0000, 6, PAR_EVEN, STOP_ONE), 0, ST_OK, 0, 0, 0);
        add_row(1_843_200, make_req(115200, 8, PAR_NONE, STOP_ONE), 0, ST_OK, 0, 0, 0);
        add_row(1_843_200, make_req(10000, 7, PAR_ODD, STOP_TWO), 0, ST_OK, 0, 0, 0);

        // hold synchronous reset, then release it just after a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table, no idling on either side
        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            if (row.rate != clock_hz)
                set_clock_rate(row.rate);
            send_beat(row.req, row.typed ? row.result : line_setup(row.req, clock_hz));
        end

        // random groups: each idling style runs in two groups, each with its own clock rate
        for (int g = 0; g < RATE_GROUPS; g++) begin
            case (g)
                0:       rate = 32'hffff_ffff;
                1:       rate = 32'd0;
                2:       rate = 32'd100_000_000;
                3:       rate = $urandom;
                4:       rate = 32'd24_000_000;
                5:       rate = $urandom_range(65535, 1);
                6:       rate = $urandom;
                default: rate = 32'd1_843_200;
            endcase
            set_clock_rate(rate);
            case (g % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 51; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 51; end
                default: begin src_idle_pct = 16; sink_stall_pct = 16; end
            endcase
            for (int n = 0; n < ITEMS_PER_GROUP; n++) begin
                // let the whole pipeline empty once mid-stream
                if (g == 2 && n == ITEMS_PER_GROUP / 2)
                    hold_until_drained();
                req = random_req(clock_hz);
                send_beat(req, line_setup(req, clock_hz));
            end
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("uart_baud_divisor_and_line_control_tb: done, clean");
        end else begin
            $display("uart_baud_divisor_and_line_control_tb: done, errors");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/ubdlc_pkg.sv
design/ubdlc_front.sv
design/ubdlc_queue.sv
design/ubdlc_back.sv
design/uart_baud_divisor_and_line_control.sv
bench/uart_baud_divisor_and_line_control_tb.sv
